// ----- rtl/cec_pkg.sv -----
// Shared constants, types and codes of the clamped-edge convolution core.
package cec_pkg;

    // Frame store and kernel geometry.
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_RADIUS   = 3;
    localparam int KSIDE        = 2 * MAX_RADIUS + 1;
    localparam int KDEPTH       = KSIDE * KSIDE;

    // Field and index widths.
    localparam int X_W          = $clog2(MAX_WIDTH);
    localparam int Y_W          = $clog2(MAX_HEIGHT);
    localparam int FADDR_W      = X_W + Y_W;
    localparam int KADDR_W      = $clog2(KDEPTH);
    localparam int TAP_W        = $clog2(KSIDE);
    localparam int RAD_W        = 2;
    localparam int SIZE_W       = 9;
    localparam int COORD_W      = X_W + 2;
    localparam int PIX_W        = 32;
    localparam int CH_W         = 8;
    localparam int COEF_W       = 16;
    localparam int ACC_W        = 30;

    // Opcodes carried in tuser.
    typedef enum logic [1:0] {
        OP_WRITE_PIXEL = 2'd0,
        OP_WRITE_COEF  = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_RADIUS_X     = 2'd2,
        CFG_RADIUS_Y     = 2'd3
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic tap_valid;
    } t_mac_ctrl;

endpackage

// ----- rtl/cec_frame_store.sv -----
// Frame store: one write port, one read port with registered read data.
module cec_frame_store
    import cec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [FADDR_W-1:0] i_waddr,
    input  logic [PIX_W-1:0]   i_wdata,
    input  logic               i_re,
    input  logic [FADDR_W-1:0] i_raddr,
    output logic [PIX_W-1:0]   o_rdata
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cec_kernel_store.sv -----
// Kernel coefficient table: one write port, one registered read port.
module cec_kernel_store
    import cec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [KADDR_W-1:0] i_waddr,
    input  logic [COEF_W-1:0]  i_wdata,
    input  logic               i_re,
    input  logic [KADDR_W-1:0] i_raddr,
    output logic [COEF_W-1:0]  o_rdata
);

    logic [COEF_W-1:0] r_mem [KDEPTH];
    logic [COEF_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cec_mac_unit.sv -----
// Four-lane multiply-accumulate unit with shift, floor at zero and saturation.
module cec_mac_unit
    import cec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctrl         i_ctrl,
    input  logic [PIX_W-1:0]  i_pix,
    input  logic [COEF_W-1:0] i_coef,
    output logic [PIX_W-1:0]  o_result
);

    logic                    r_valid;
    logic signed [ACC_W-1:0] r_acc [4];
    logic signed [ACC_W-1:0] n_acc [4];

    // Turns an accumulated sum into an 8-bit channel value.
    function automatic logic [CH_W-1:0] finish(input logic signed [ACC_W-1:0] sum);
        logic [ACC_W-9:0] q;
        q = sum[ACC_W-1:8];
        if (sum <= 0) begin
            finish = '0;
        end else if (q > (ACC_W-8)'(255)) begin
            finish = 8'hFF;
        end else begin
            finish = q[CH_W-1:0];
        end
    endfunction

    // Read data arrives in the cycle after the tap address was issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.tap_valid;
        end
    end

    // One product per lane and tap, added into the lane accumulator.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_acc[k] = r_acc[k];
            if (i_ctrl.clear) begin
                n_acc[k] = '0;
            end else if (r_valid) begin
                n_acc[k] = r_acc[k] + ACC_W'($signed(i_coef)
                           * $signed({1'b0, i_pix[k*CH_W +: CH_W]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_acc[k] <= n_acc[k];
        end
    end

    // Final channel values, lowest channel in the lowest byte.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_result[k*CH_W +: CH_W] = finish(r_acc[k]);
        end
    end

endmodule

// ----- rtl/clamped_edge_convolution_core.sv -----
// Top level: stream ports, configuration registers and the tap sequencer.
// Write words (pixel or coefficient) are taken in the idle state and leave the sequencer idle.
// A compute word runs the tap sweep over a (2*radius_x+1) by (2*radius_y+1) window,
// one frame-store read per tap, then drains and loads the result register.
// A new word is accepted only while the sequencer is idle; the result waits in an
// output register. Synchronous active-low reset clears control and configuration
// (width 256, height 256, radii 1); the frame store and kernel table are not cleared.
module clamped_edge_convolution_core
    import cec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: pos_x[7:0], pos_y[15:8], coef_index[21:16], coef_value[37:22],
    // in_red[45:38], in_green[53:46], in_blue[61:54], in_alpha[69:62], zero [71:70]
    input  logic [71:0]   s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]    s_axis_tuser,
    // Result stream.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0]   m_axis_tdata,
    // Configuration write channel.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_addr,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    // Input fields.
    t_opcode             in_op;
    logic [X_W-1:0]      in_x;
    logic [Y_W-1:0]      in_y;
    logic [5:0]          in_cidx;
    logic [COEF_W-1:0]   in_coef;
    logic [PIX_W-1:0]    in_pix;

    assign in_op   = t_opcode'(s_axis_tuser);
    assign in_x    = s_axis_tdata[7:0];
    assign in_y    = s_axis_tdata[15:8];
    assign in_cidx = s_axis_tdata[21:16];
    assign in_coef = s_axis_tdata[37:22];
    assign in_pix  = s_axis_tdata[69:38];

    // Configuration registers.
    logic [SIZE_W-1:0] r_fw, r_fh;
    logic [RAD_W-1:0]  r_rx, r_ry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= SIZE_W'(MAX_WIDTH);
            r_fh <= SIZE_W'(MAX_HEIGHT);
            r_rx <= RAD_W'(1);
            r_ry <= RAD_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                CFG_RADIUS_X:     r_rx <= i_cfg_data[RAD_W-1:0];
                CFG_RADIUS_Y:     r_ry <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero counts as one, oversize as the maximum.
    logic [SIZE_W-1:0] eff_w, eff_h;
    logic [X_W-1:0]    lim_x;
    logic [Y_W-1:0]    lim_y;

    always_comb begin
        if (r_fw == '0) begin
            eff_w = SIZE_W'(1);
        end else if (r_fw > SIZE_W'(MAX_WIDTH)) begin
            eff_w = SIZE_W'(MAX_WIDTH);
        end else begin
            eff_w = r_fw;
        end
        if (r_fh == '0) begin
            eff_h = SIZE_W'(1);
        end else if (r_fh > SIZE_W'(MAX_HEIGHT)) begin
            eff_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_fh;
        end
    end

    assign lim_x = X_W'(eff_w - SIZE_W'(1));
    assign lim_y = Y_W'(eff_h - SIZE_W'(1));

    // Sequencer registers.
    t_state            r_state, n_state;
    logic [X_W-1:0]    r_px;
    logic [Y_W-1:0]    r_py;
    logic [TAP_W-1:0]  r_tap_i, n_tap_i;
    logic [TAP_W-1:0]  r_tap_j, n_tap_j;
    logic [KADDR_W-1:0] r_cell, n_cell;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_data;
    logic              out_load;

    logic              accept;
    logic [TAP_W-1:0]  win_w, win_h;
    logic              last_col, last_row;
    t_mac_ctrl         mac_ctrl;
    logic [PIX_W-1:0]  mac_result;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign win_w         = {r_rx, 1'b1};
    assign win_h         = {r_ry, 1'b1};
    assign last_col      = (r_tap_i == win_w - TAP_W'(1));
    assign last_row      = (r_tap_j == win_h - TAP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap_i <= n_tap_i;
        r_tap_j <= n_tap_j;
        r_cell  <= n_cell;
        if (accept) begin
            r_px <= in_x;
            r_py <= in_y;
        end
        if (out_load) begin
            r_out_data <= mac_result;
        end
    end

    // Next state, tap counters and output register control.
    always_comb begin
        n_state        = r_state;
        n_tap_i        = r_tap_i;
        n_tap_j        = r_tap_j;
        n_cell         = r_cell;
        out_load       = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.tap_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_tap_i = '0;
                n_tap_j = '0;
                n_cell  = '0;
                if (accept && in_op == OP_COMPUTE) begin
                    mac_ctrl.clear = 1'b1;
                    n_state        = ST_TAPS;
                end
            end
            ST_TAPS: begin
                mac_ctrl.tap_valid = 1'b1;
                n_cell = r_cell + KADDR_W'(1);
                if (last_col) begin
                    n_tap_i = '0;
                    n_tap_j = r_tap_j + TAP_W'(1);
                    if (last_row) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_tap_i = r_tap_i + TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Neighbor coordinates clamped to the frame edges.
    logic signed [COORD_W-1:0] raw_x, raw_y;
    logic [X_W-1:0]            src_x;
    logic [Y_W-1:0]            src_y;

    always_comb begin
        raw_x = $signed({2'b00, r_px}) + $signed(COORD_W'(r_tap_i))
                - $signed(COORD_W'(r_rx));
        raw_y = $signed({2'b00, r_py}) + $signed(COORD_W'(r_tap_j))
                - $signed(COORD_W'(r_ry));
        if (raw_x < 0) begin
            src_x = '0;
        end else if (raw_x > $signed({2'b00, lim_x})) begin
            src_x = lim_x;
        end else begin
            src_x = raw_x[X_W-1:0];
        end
        if (raw_y < 0) begin
            src_y = '0;
        end else if (raw_y > $signed({2'b00, lim_y})) begin
            src_y = lim_y;
        end else begin
            src_y = raw_y[Y_W-1:0];
        end
    end

    // Write decode: pixels inside the frame and coefficients inside the table.
    logic pix_we, coef_we;

    assign pix_we  = accept && in_op == OP_WRITE_PIXEL
                     && {1'b0, in_x} < eff_w && {1'b0, in_y} < eff_h;
    assign coef_we = accept && in_op == OP_WRITE_COEF && in_cidx < KADDR_W'(KDEPTH);

    logic [PIX_W-1:0]  frame_rdata;
    logic [COEF_W-1:0] coef_rdata;

    cec_frame_store u_frame_store (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr ({in_y, in_x}),
        .i_wdata (in_pix),
        .i_re    (mac_ctrl.tap_valid),
        .i_raddr ({src_y, src_x}),
        .o_rdata (frame_rdata)
    );

    cec_kernel_store u_kernel_store (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (in_cidx[KADDR_W-1:0]),
        .i_wdata (in_coef),
        .i_re    (mac_ctrl.tap_valid),
        .i_raddr (r_cell),
        .o_rdata (coef_rdata)
    );

    cec_mac_unit u_mac_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_pix    (frame_rdata),
        .i_coef   (coef_rdata),
        .o_result (mac_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A compute word starts the tap sweep in the next cycle.
    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_op == OP_COMPUTE |=> r_state == ST_TAPS)
        else $error("compute word did not start the tap sweep");

    // Tap counters stay inside the window during the sweep.
    a_tap_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TAPS |-> r_tap_i < win_w && r_tap_j < win_h)
        else $error("tap counter outside the window");

    // Kernel cell index stays inside the table.
    a_cell_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TAPS |-> r_cell < KADDR_W'(KDEPTH))
        else $error("kernel cell index beyond the table");

    // The drain cycle only follows the last tap.
    a_drain_after_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> $past(r_state) == ST_TAPS)
        else $error("drain entered without a tap sweep");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_out_valid || m_axis_tready)
        else $error("result overwrote a waiting word");
`endif

endmodule
